// ----- src/hcd_pkg.sv -----
// hcd_pkg: shared types and constants of the header checksum packet deframer
// no dependencies; imported by the deframer top level

package hcd_pkg;

  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 2'd1;

  localparam logic [7:0] HEADER_FIRST_RESET  = 8'hAA;
  localparam logic [7:0] HEADER_SECOND_RESET = 8'h55;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_HDR0 = 5'b00010,
    ST_HDR1 = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_LOAD = 5'b10000
  } state_e;

endpackage

// ----- src/hcd_ram.sv -----
// hcd_ram: generic single-port-write, single-port-read RAM with registered read
// no dependencies; used by the deframer for the byte window

module hcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 12
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ----- src/header_checksum_packet_deframer.sv -----
// header_checksum_packet_deframer: sliding-window deframer with header and sum check
// depends on hcd_pkg and hcd_ram (circular byte window)
//
// channel   direction  handshake                    payload
// rx        in         rx_valid_i / rx_ready_o      rx_byte_i
// payload   out        payload_valid_o / _ready_i   payload_byte_o, payload_last_o
// cfg       in         cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// a byte that leaves the window short of full is taken in IDLE, which stays ready for the next
// a byte that fills the window starts the check in HDR0 and HDR1: the two header bytes are
// read one after the other through the single read port of the window RAM
// a passing packet then takes each payload byte through EMIT (read) and LOAD (load output)
// output stalls hold payload emission; rx is taken meanwhile only once the
// last payload byte sits in the output register; no clearing pass after reset

module header_checksum_packet_deframer
  import hcd_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rx_valid_i,
  output logic                   rx_ready_o,
  input  logic [7:0]             rx_byte_i,
  output logic                   payload_valid_o,
  input  logic                   payload_ready_i,
  output logic [7:0]             payload_byte_o,
  output logic                   payload_last_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [7:0]             cfg_data_i
);

  localparam int unsigned AW = $clog2(PACKET_BYTES);
  localparam int unsigned FW = $clog2(PACKET_BYTES + 1);
  localparam int unsigned PAYLOAD_BYTES = PACKET_BYTES - 4;
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(PACKET_BYTES);

  typedef logic [AW-1:0] addr_t;

  function automatic addr_t wrap_add(addr_t base, addr_t off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  state_e        state_q, state_d;
  addr_t         head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [15:0]   sum_q, sum_d;
  logic [7:0]    prev_q, prev_d;
  logic [7:0]    cur_q, cur_d;
  logic [7:0]    h0_q, h0_d;
  addr_t         k_q, k_d;
  logic [7:0]    hfirst_q, hfirst_d;
  logic [7:0]    hsecond_q, hsecond_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;

  logic        rx_acc;
  logic        out_free;
  logic        full_next;
  logic        k_last;
  logic        pass;
  logic [15:0] body_sum;
  logic        rd_en;
  addr_t       rd_addr;
  addr_t       wr_addr;
  logic [7:0]  rd_data;

  assign rx_ready_o      = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign payload_valid_o = out_valid_q;
  assign payload_byte_o  = out_byte_q;
  assign payload_last_o  = out_last_q;

  assign rx_acc    = rx_valid_i && rx_ready_o;
  assign out_free  = !out_valid_q || payload_ready_i;
  assign full_next = (fill_q == FW'(PACKET_BYTES - 1));
  assign k_last    = (k_q == addr_t'(PAYLOAD_BYTES - 1));
  assign wr_addr   = wrap_add(head_q, fill_q[AW-1:0]);
  assign body_sum  = sum_q - {8'h00, prev_q} - {8'h00, cur_q};
  assign pass      = (h0_q == hfirst_q) && (rd_data == hsecond_q) &&
                     (body_sum == {cur_q, prev_q});

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_q;
    case (state_q)
      ST_IDLE: begin
        rd_en = rx_acc && full_next;
      end
      ST_HDR0: begin
        rd_en   = 1'b1;
        rd_addr = wrap_add(head_q, addr_t'(1));
      end
      ST_EMIT: begin
        rd_en   = out_free;
        rd_addr = wrap_add(head_q, k_q + addr_t'(2));
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  hcd_ram #(
    .WIDTH(8),
    .DEPTH(PACKET_BYTES)
  ) u_window_ram (
    .clk_i    (clk_i),
    .wr_en_i  (rx_acc),
    .wr_addr_i(wr_addr),
    .wr_data_i(rx_byte_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    h0_d        = h0_q;
    k_d         = k_q;
    hfirst_d    = hfirst_q;
    hsecond_d   = hsecond_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (out_valid_q && payload_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_HEADER_FIRST:  hfirst_d  = cfg_data_i;
        REG_HEADER_SECOND: hsecond_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (rx_acc) begin
          fill_d = fill_q + FW'(1);
          sum_d  = sum_q + {8'h00, rx_byte_i};
          prev_d = cur_q;
          cur_d  = rx_byte_i;
          if (full_next) begin
            state_d = ST_HDR0;
          end
        end
      end
      ST_HDR0: begin
        h0_d    = rd_data;
        state_d = ST_HDR1;
      end
      ST_HDR1: begin
        if (pass) begin
          k_d     = '0;
          state_d = ST_EMIT;
        end else begin
          // drop the oldest byte and slide the window
          sum_d   = sum_q - {8'h00, h0_q};
          head_d  = wrap_add(head_q, addr_t'(1));
          fill_d  = FW'(PACKET_BYTES - 1);
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        out_valid_d = 1'b1;
        out_byte_d  = rd_data;
        out_last_d  = k_last;
        if (k_last) begin
          head_d  = '0;
          fill_d  = '0;
          sum_d   = '0;
          state_d = ST_IDLE;
        end else begin
          k_d     = k_q + addr_t'(1);
          state_d = ST_EMIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      k_q         <= '0;
      hfirst_q    <= HEADER_FIRST_RESET;
      hsecond_q   <= HEADER_SECOND_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      k_q         <= k_d;
      hfirst_q    <= hfirst_d;
      hsecond_q   <= hsecond_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    h0_q       <= h0_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

endmodule

// ----- src/hcd_checker.sv -----
// hcd_checker: port-level checks on the header checksum packet deframer
// no package needed; bound to header_checksum_packet_deframer below

module hcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_ready_o,
  input logic       payload_valid_o,
  input logic       payload_ready_i,
  input logic [7:0] payload_byte_o,
  input logic       payload_last_o
);

  // stalled output item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    payload_valid_o && !payload_ready_i |=>
      payload_valid_o && $stable(payload_byte_o) && $stable(payload_last_o))
    else $error("stalled payload item changed");

  // a packet is still being emitted while a non-last byte is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    payload_valid_o && !payload_last_o |-> !rx_ready_o)
    else $error("rx taken in the middle of a packet");

  // after a non-last byte is taken, more of the packet follows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    payload_valid_o && payload_ready_i && !payload_last_o |=> !rx_ready_o)
    else $error("packet ended without a last byte");

  // emission never starts in the cycle right after an rx item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid_i && rx_ready_o |=> !$rose(payload_valid_o))
    else $error("payload appeared too early after rx item");

endmodule

bind header_checksum_packet_deframer hcd_checker u_hcd_checker (.*);
